// ===== design/spb_pkg.sv =====
// spb_pkg: shared types, codes and sizes for the segment presence bitmap.
// Used by spb_ctrl, spb_dp and segment_presence_bitmap_top. No dependencies.
`timescale 1ns / 1ps

package spb_pkg;

	localparam int MAP_BITS     = 64;
	localparam int IDX_W        = 6;
	localparam int SPAN_W       = 7;
	localparam int ECHO_W       = 16;
	localparam int RESULT_LIMIT = 64;

	localparam logic [2:0] CMD_MARK_WRITTEN   = 3'd0;
	localparam logic [2:0] CMD_MARK_ERASED    = 3'd1;
	localparam logic [2:0] CMD_CLEAR_ALL      = 3'd2;
	localparam logic [2:0] CMD_MISSING_RUNS   = 3'd3;
	localparam logic [2:0] CMD_EXISTING_RUNS  = 3'd4;
	localparam logic [2:0] CMD_MISSING_INDEX  = 3'd5;
	localparam logic [2:0] CMD_EXISTING_INDEX = 3'd6;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FOUND = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	typedef struct packed {
		logic [2:0]        command;
		logic [IDX_W-1:0]  segment_index;
		logic [ECHO_W-1:0] element_size;
	} item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  run_start;
		logic [IDX_W-1:0]  run_end;
		logic [ECHO_W-1:0] size_echo;
		logic [SPAN_W-1:0] missing_count;
		logic [SPAN_W-1:0] existing_count;
		logic              last;
	} result_t;

	typedef struct packed {
		logic mark;
		logic query;
		logic cfg_load;
		logic scan;
		logic recount;
		logic flush;
	} ctrl_t;

	typedef struct packed {
		logic scan_last;
		logic limit_hit;
	} stat_t;

	function automatic logic is_query(input logic [2:0] c);
		return (c == CMD_MISSING_RUNS) || (c == CMD_EXISTING_RUNS) ||
			(c == CMD_MISSING_INDEX) || (c == CMD_EXISTING_INDEX);
	endfunction

endpackage

// ===== design/segment_presence_bitmap_top.sv =====
// segment_presence_bitmap_top: presence bitmap with run and index listing.
// Depends on spb_pkg, spb_ctrl, spb_dp.
//
//  channel   handshake                 beat
//  --------  ------------------------  ---------------------------------
//  item      start & !busy             command, segment_index, element_size
//  result    result_valid (one cycle)  kind, run/index, echo, counts, last
//  config    cfg_valid & cfg_ready     active_size
//
// Mark, clear and unused commands: one beat per cycle, result in the next
// cycle, busy stays low. List queries: busy while the map is walked (one
// map bit per cycle, up to span = min(active_size, 64) bits or until the
// result limit, then a final beat). A config write busies the block while
// the set count is rebuilt one bit per cycle. Reset clears the map;
// active_size returns to 64. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module segment_presence_bitmap_top
	import spb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output result_t           result,
	output logic              result_valid,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SPAN_W-1:0] cfg_data
);

	ctrl_t ctrl;
	stat_t stat;

	spb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (item.command),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	spb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.item         (item),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== design/spb_ctrl.sv =====
// spb_ctrl: sequencer for map walks (query scan, recount after config).
// Depends on spb_pkg.
`timescale 1ns / 1ps

module spb_ctrl
	import spb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] command,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	output logic       busy,
	input  stat_t      stat,
	output ctrl_t      ctrl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_RECOUNT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign busy      = busy_q;
	assign cfg_ready = !busy_q && !start;
	assign accept    = start && !busy_q;

	always_comb begin
		ctrl          = '0;
		ctrl.mark     = accept && !is_query(command);
		ctrl.query    = accept && is_query(command);
		ctrl.cfg_load = cfg_valid && cfg_ready;
		ctrl.scan     = (state_q == ST_SCAN);
		ctrl.recount  = (state_q == ST_RECOUNT);
		ctrl.flush    = (state_q == ST_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.query) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end else if (ctrl.cfg_load) begin
						state_q <= ST_RECOUNT;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last || stat.limit_hit) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				ST_RECOUNT: begin
					if (stat.scan_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== design/spb_dp.sv =====
// spb_dp: presence map, set count, run/index walker and result register.
// Depends on spb_pkg; driven by spb_ctrl commands.
`timescale 1ns / 1ps

module spb_dp
	import spb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	output stat_t             stat,
	input  item_t             item,
	input  logic [SPAN_W-1:0] cfg_data,
	output result_t           result,
	output logic              result_valid
);

	localparam logic [SPAN_W-1:0] SPAN_MAX  = SPAN_W'(MAP_BITS);
	localparam logic [SPAN_W-1:0] LIMIT_PRE = SPAN_W'(RESULT_LIMIT - 2);

	logic [MAP_BITS-1:0] map_q;
	logic [SPAN_W-1:0]   active_q;
	logic [SPAN_W-1:0]   exist_q;
	logic [IDX_W-1:0]    idx_q;
	logic                inside_q;
	logic [IDX_W-1:0]    start_q;
	logic                target_q;
	logic                runs_q;
	logic [ECHO_W-1:0]   echo_q;
	logic                pend_valid_q;
	logic [IDX_W-1:0]    pend_start_q;
	logic [IDX_W-1:0]    pend_end_q;
	logic [SPAN_W-1:0]   count_q;
	logic                out_valid_q;
	logic [1:0]          out_kind_q;
	logic [IDX_W-1:0]    out_start_q;
	logic [IDX_W-1:0]    out_end_q;
	logic [ECHO_W-1:0]   out_echo_q;
	logic                out_last_q;

	logic [SPAN_W-1:0] span;
	logic [SPAN_W-1:0] idx_ext;
	logic              in_range;
	logic              hit;
	logic              found;
	logic [IDX_W-1:0]  f_start;
	logic [IDX_W-1:0]  f_end;
	logic              seg_err;
	logic              seg_active;
	logic              seg_bit;

	assign span     = (active_q > SPAN_MAX) ? SPAN_MAX : active_q;
	assign idx_ext  = {1'b0, idx_q};
	assign in_range = idx_ext < span;
	assign hit      = in_range && (map_q[idx_q] == target_q);

	assign stat.scan_last = (idx_ext + SPAN_W'(1)) >= span;
	assign stat.limit_hit = found && pend_valid_q && (count_q == LIMIT_PRE);

	always_comb begin
		if (runs_q) begin
			found   = in_range && ((hit && stat.scan_last) || (!hit && inside_q));
			f_start = inside_q ? start_q : idx_q;
			f_end   = hit ? idx_q : idx_q - IDX_W'(1);
		end else begin
			found   = hit;
			f_start = idx_q;
			f_end   = idx_q;
		end
	end

	assign seg_err    = {1'b0, item.segment_index} >= SPAN_MAX;
	assign seg_active = {1'b0, item.segment_index} < span;
	assign seg_bit    = map_q[item.segment_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q        <= '0;
			active_q     <= SPAN_MAX;
			exist_q      <= '0;
			idx_q        <= '0;
			inside_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			if (ctrl.cfg_load) begin
				active_q <= cfg_data;
				exist_q  <= '0;
				idx_q    <= '0;
			end
			if (ctrl.recount) begin
				if (in_range && map_q[idx_q]) begin
					exist_q <= exist_q + SPAN_W'(1);
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			if (ctrl.query) begin
				idx_q        <= '0;
				inside_q     <= 1'b0;
				pend_valid_q <= 1'b0;
				count_q      <= '0;
			end
			if (ctrl.mark) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= KIND_ACK;
				out_start_q <= '0;
				out_end_q   <= '0;
				out_echo_q  <= '0;
				out_last_q  <= 1'b1;
				case (item.command)
					CMD_MARK_WRITTEN, CMD_MARK_ERASED: begin
						if (seg_err) begin
							out_kind_q  <= KIND_ERROR;
							out_start_q <= item.segment_index;
							out_end_q   <= item.segment_index;
						end else begin
							map_q[item.segment_index] <= (item.command == CMD_MARK_WRITTEN);
							if (seg_active) begin
								if (item.command == CMD_MARK_WRITTEN && !seg_bit) begin
									exist_q <= exist_q + SPAN_W'(1);
								end else if (item.command == CMD_MARK_ERASED && seg_bit) begin
									exist_q <= exist_q - SPAN_W'(1);
								end
							end
						end
					end
					CMD_CLEAR_ALL: begin
						map_q   <= '0;
						exist_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (ctrl.scan) begin
				idx_q    <= idx_q + IDX_W'(1);
				inside_q <= hit;
				if (found) begin
					pend_valid_q <= 1'b1;
					pend_start_q <= f_start;
					pend_end_q   <= f_end;
					if (pend_valid_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_FOUND;
						out_start_q <= pend_start_q;
						out_end_q   <= pend_end_q;
						out_echo_q  <= echo_q;
						out_last_q  <= 1'b0;
						count_q     <= count_q + SPAN_W'(1);
					end
				end
			end
			if (ctrl.flush) begin
				out_valid_q <= 1'b1;
				out_echo_q  <= echo_q;
				out_last_q  <= 1'b1;
				if (pend_valid_q) begin
					out_kind_q  <= KIND_FOUND;
					out_start_q <= pend_start_q;
					out_end_q   <= pend_end_q;
				end else begin
					out_kind_q  <= KIND_NONE;
					out_start_q <= '0;
					out_end_q   <= '0;
				end
			end
		end
	end

	// query descriptor and run start
	always_ff @(posedge clk) begin
		if (ctrl.query) begin
			target_q <= (item.command == CMD_EXISTING_RUNS) ||
				(item.command == CMD_EXISTING_INDEX);
			runs_q   <= (item.command == CMD_MISSING_RUNS) ||
				(item.command == CMD_EXISTING_RUNS);
			echo_q   <= item.element_size;
		end
		if (ctrl.scan && hit && !inside_q) begin
			start_q <= idx_q;
		end
	end

	assign result_valid = out_valid_q;

	always_comb begin
		result                = '0;
		result.kind           = out_kind_q;
		result.run_start      = out_start_q;
		result.run_end        = out_end_q;
		result.size_echo      = out_echo_q;
		result.existing_count = exist_q;
		result.missing_count  = span - exist_q;
		result.last           = out_last_q;
	end

endmodule
